/* hw/rtl/drt_pkg.sv */
// -----------------------------------------------------------------------------
// drt_pkg: damage rectangle tracker shared definitions
// Field widths, operation and result codes, the queue command and the clip
// function used by both the front and the back.
// -----------------------------------------------------------------------------
package drt_pkg;

	localparam int MAX_RECTS    = 40;
	localparam int CURSOR_BOX_W = 28;
	localparam int CURSOR_BOX_H = 32;
	localparam int CURSOR_OFS   = 2;
	localparam int SCREEN_LIMIT = 4096;

	localparam int OP_W    = 2;
	localparam int POS_W   = 16;
	localparam int PAD_W   = 8;
	localparam int XY_W    = 12;
	localparam int DIM_W   = 13;
	localparam int KIND_W  = 2;
	localparam int COORD_W = 20;
	localparam int IDX_W   = $clog2(MAX_RECTS);
	localparam int CNT_W   = $clog2(MAX_RECTS + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_DAMAGE = 2'd0;
	localparam logic [OP_W-1:0] OP_FULL   = 2'd1;
	localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_FULL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RECT = 2'd2;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic  ok;
		rect_t r;
	} clip_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		clip_t                   rect;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ADD,
		B_SEARCH,
		B_FLUSH
	} back_state_t;

	function automatic clip_t clip_rect(coord_t x, coord_t y, coord_t w, coord_t h,
		logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh);
		coord_t cx;
		coord_t cy;
		coord_t cw;
		coord_t ch;
		coord_t swe;
		coord_t she;
		clip_t  res;
		cx  = x;
		cy  = y;
		cw  = w;
		ch  = h;
		swe = {{(COORD_W-DIM_W){1'b0}}, sw};
		she = {{(COORD_W-DIM_W){1'b0}}, sh};
		res.ok = (w > 0) && (h > 0);
		if (cx < 0) begin
			cw = cw + cx;
			cx = '0;
		end
		if (cy < 0) begin
			ch = ch + cy;
			cy = '0;
		end
		if (cx + cw > swe) begin
			cw = swe - cx;
		end
		if (cy + ch > she) begin
			ch = she - cy;
		end
		res.ok  = res.ok && (cw > 0) && (ch > 0);
		res.r.x = cx[XY_W-1:0];
		res.r.y = cy[XY_W-1:0];
		res.r.w = cw[DIM_W-1:0];
		res.r.h = ch[DIM_W-1:0];
		return res;
	endfunction

endpackage

/* hw/rtl/drt_if.sv */
// -----------------------------------------------------------------------------
// drt_if: damage rectangle tracker channels
// Operation input, result output and configuration write channels.
// -----------------------------------------------------------------------------
interface drt_in_if;
	logic                                valid;
	logic                                ready;
	logic [drt_pkg::OP_W-1:0]            operation;
	logic signed [drt_pkg::POS_W-1:0]    pos_x;
	logic signed [drt_pkg::POS_W-1:0]    pos_y;
	logic signed [drt_pkg::POS_W-1:0]    rect_w;
	logic signed [drt_pkg::POS_W-1:0]    rect_h;
	logic [drt_pkg::PAD_W-1:0]           pad;

	modport source (output valid, operation, pos_x, pos_y, rect_w, rect_h, pad, input ready);
	modport sink (input valid, operation, pos_x, pos_y, rect_w, rect_h, pad, output ready);
endinterface

interface drt_out_if;
	logic                        valid;
	logic                        ready;
	logic [drt_pkg::KIND_W-1:0]  kind;
	logic [drt_pkg::XY_W-1:0]    out_x;
	logic [drt_pkg::XY_W-1:0]    out_y;
	logic [drt_pkg::DIM_W-1:0]   out_w;
	logic [drt_pkg::DIM_W-1:0]   out_h;
	logic                        last;

	modport source (output valid, kind, out_x, out_y, out_w, out_h, last, input ready);
	modport sink (input valid, kind, out_x, out_y, out_w, out_h, last, output ready);
endinterface

interface drt_cfg_if;
	logic                       valid;
	logic                       ready;
	logic                       index;
	logic [drt_pkg::DIM_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/drt_front.sv */
// -----------------------------------------------------------------------------
// drt_front: operation decode and rectangle clipping
// Pads and clips damage rectangles, builds the new cursor box, and hands one
// command per transaction to the queue.
// -----------------------------------------------------------------------------
module drt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	drt_in_if.sink                        ops,
	input  logic [drt_pkg::DIM_W-1:0]     sw,
	input  logic [drt_pkg::DIM_W-1:0]     sh,
	output logic                          push,
	output drt_pkg::cmd_t                 push_cmd,
	input  logic                          q_rdy
);

	logic              vld_s1;
	drt_pkg::cmd_t     cmd_s1;
	drt_pkg::cmd_t     cmd_d;
	logic              accept;
	drt_pkg::coord_t   px;
	drt_pkg::coord_t   py;
	drt_pkg::coord_t   pad2;
	drt_pkg::coord_t   padv;

	assign ops.ready = !vld_s1 || q_rdy;
	assign accept    = ops.valid && ops.ready;
	assign push      = vld_s1;
	assign push_cmd  = cmd_s1;

	always_comb begin
		px   = {{(drt_pkg::COORD_W-drt_pkg::POS_W){ops.pos_x[drt_pkg::POS_W-1]}}, ops.pos_x};
		py   = {{(drt_pkg::COORD_W-drt_pkg::POS_W){ops.pos_y[drt_pkg::POS_W-1]}}, ops.pos_y};
		padv = {{(drt_pkg::COORD_W-drt_pkg::PAD_W){1'b0}}, ops.pad};
		pad2 = {{(drt_pkg::COORD_W-drt_pkg::PAD_W-1){1'b0}}, ops.pad, 1'b0};
		cmd_d.op    = ops.operation;
		cmd_d.pos_x = ops.pos_x;
		cmd_d.pos_y = ops.pos_y;
		if (ops.operation == drt_pkg::OP_CURSOR) begin
			cmd_d.rect = drt_pkg::clip_rect(
				px - drt_pkg::coord_t'(drt_pkg::CURSOR_OFS),
				py - drt_pkg::coord_t'(drt_pkg::CURSOR_OFS),
				drt_pkg::coord_t'(drt_pkg::CURSOR_BOX_W),
				drt_pkg::coord_t'(drt_pkg::CURSOR_BOX_H), sw, sh);
		end else begin
			cmd_d.rect = drt_pkg::clip_rect(
				px - padv, py - padv,
				{{(drt_pkg::COORD_W-drt_pkg::POS_W){ops.rect_w[drt_pkg::POS_W-1]}},
					ops.rect_w} + pad2,
				{{(drt_pkg::COORD_W-drt_pkg::POS_W){ops.rect_h[drt_pkg::POS_W-1]}},
					ops.rect_h} + pad2,
				sw, sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !q_rdy);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* hw/rtl/drt_queue.sv */
// -----------------------------------------------------------------------------
// drt_queue: command queue between front and back
// Small first-in first-out buffer; the back reads the head in place and pops
// it when the command is done.
// -----------------------------------------------------------------------------
module drt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  drt_pkg::cmd_t   push_cmd,
	output logic            q_rdy,
	output logic            head_vld,
	output drt_pkg::cmd_t   head,
	input  logic            pop
);

	drt_pkg::cmd_t                 slots_q [drt_pkg::QUEUE_DEPTH];
	logic [drt_pkg::QPTR_W-1:0]    wr_q;
	logic [drt_pkg::QPTR_W-1:0]    rd_q;
	logic [drt_pkg::QCNT_W-1:0]    cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign q_rdy    = cnt_q != drt_pkg::QCNT_W'(drt_pkg::QUEUE_DEPTH);
	assign head_vld = cnt_q != '0;
	assign head     = slots_q[rd_q];
	assign do_push  = push && q_rdy;
	assign do_pop   = pop && head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == drt_pkg::QPTR_W'(drt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == drt_pkg::QPTR_W'(drt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/drt_back.sv */
// -----------------------------------------------------------------------------
// drt_back: rectangle list execution
// Holds the rectangle store, count, full-redraw flag and cursor position;
// runs the duplicate search, appends, and walks the store on a render.
// -----------------------------------------------------------------------------
module drt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [drt_pkg::DIM_W-1:0]     sw,
	input  logic [drt_pkg::DIM_W-1:0]     sh,
	input  logic                          cmd_vld,
	input  drt_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	drt_out_if.source                     rsp
);

	drt_pkg::rect_t                    mem [drt_pkg::MAX_RECTS];
	drt_pkg::rect_t                    rd_data_q;

	drt_pkg::back_state_t              state_q, state_d;
	logic [drt_pkg::CNT_W-1:0]         count_q, count_d;
	logic [drt_pkg::CNT_W-1:0]         rd_q, rd_d;
	logic                              pend_q, pend_d;
	logic                              full_q, full_d;
	logic                              known_q, known_d;
	logic signed [drt_pkg::POS_W-1:0]  cur_x_q, cur_x_d;
	logic signed [drt_pkg::POS_W-1:0]  cur_y_q, cur_y_d;
	drt_pkg::clip_t                    work_q, work_d;
	logic                              second_q, second_d;
	logic                              out_vld_q;

	drt_pkg::rect_t                    out_rect_q;
	logic [drt_pkg::KIND_W-1:0]        out_kind_q;
	logic                              out_last_q;

	logic                              mem_we;
	logic                              mem_re;
	logic                              out_free;
	logic                              match;
	logic                              finish;
	logic                              emit;
	logic [drt_pkg::KIND_W-1:0]        emit_kind;
	drt_pkg::rect_t                    emit_rect;
	logic                              emit_last;
	drt_pkg::clip_t                    old_box;

	assign out_free  = !out_vld_q || rsp.ready;
	assign match     = pend_q && (rd_data_q == work_q.r);
	assign rsp.valid = out_vld_q;
	assign rsp.kind  = out_kind_q;
	assign rsp.out_x = out_rect_q.x;
	assign rsp.out_y = out_rect_q.y;
	assign rsp.out_w = out_rect_q.w;
	assign rsp.out_h = out_rect_q.h;
	assign rsp.last  = out_last_q;

	always_comb begin
		old_box = drt_pkg::clip_rect(
			{{(drt_pkg::COORD_W-drt_pkg::POS_W){cur_x_q[drt_pkg::POS_W-1]}}, cur_x_q}
				- drt_pkg::coord_t'(drt_pkg::CURSOR_OFS),
			{{(drt_pkg::COORD_W-drt_pkg::POS_W){cur_y_q[drt_pkg::POS_W-1]}}, cur_y_q}
				- drt_pkg::coord_t'(drt_pkg::CURSOR_OFS),
			drt_pkg::coord_t'(drt_pkg::CURSOR_BOX_W),
			drt_pkg::coord_t'(drt_pkg::CURSOR_BOX_H), sw, sh);
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_d      = rd_q;
		pend_d    = 1'b0;
		full_d    = full_q;
		known_d   = known_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		work_d    = work_q;
		second_d  = second_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		finish    = 1'b0;
		emit      = 1'b0;
		emit_kind = drt_pkg::KIND_NONE;
		emit_rect = '0;
		emit_last = 1'b1;

		case (state_q)
			drt_pkg::B_IDLE: begin
				if (cmd_vld) begin
					case (cmd.op)
						drt_pkg::OP_DAMAGE: begin
							work_d   = cmd.rect;
							second_d = 1'b0;
							state_d  = drt_pkg::B_ADD;
						end
						drt_pkg::OP_FULL: begin
							full_d  = 1'b1;
							count_d = '0;
							cmd_pop = 1'b1;
						end
						drt_pkg::OP_CURSOR: begin
							if (!known_q) begin
								known_d = 1'b1;
								cur_x_d = cmd.pos_x;
								cur_y_d = cmd.pos_y;
								cmd_pop = 1'b1;
							end else if (full_q) begin
								cmd_pop = 1'b1;
							end else begin
								work_d   = old_box;
								second_d = 1'b1;
								state_d  = drt_pkg::B_ADD;
							end
						end
						default: begin
							if (full_q) begin
								if (out_free) begin
									emit      = 1'b1;
									emit_kind = drt_pkg::KIND_FULL;
									full_d    = 1'b0;
									count_d   = '0;
									cmd_pop   = 1'b1;
								end
							end else if (count_q == '0) begin
								if (out_free) begin
									emit      = 1'b1;
									emit_kind = drt_pkg::KIND_NONE;
									cmd_pop   = 1'b1;
								end
							end else begin
								rd_d    = '0;
								state_d = drt_pkg::B_FLUSH;
							end
						end
					endcase
				end
			end
			drt_pkg::B_ADD: begin
				if (full_q || !work_q.ok) begin
					finish = 1'b1;
				end else if (count_q >= drt_pkg::CNT_W'(drt_pkg::MAX_RECTS)) begin
					full_d  = 1'b1;
					count_d = '0;
					finish  = 1'b1;
				end else if (count_q == '0) begin
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					finish  = 1'b1;
				end else begin
					rd_d    = '0;
					state_d = drt_pkg::B_SEARCH;
				end
			end
			drt_pkg::B_SEARCH: begin
				if (match) begin
					finish = 1'b1;
				end else if (rd_q != count_q) begin
					mem_re = 1'b1;
					rd_d   = rd_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					finish  = 1'b1;
				end
			end
			drt_pkg::B_FLUSH: begin
				if (pend_q) begin
					emit      = 1'b1;
					emit_kind = drt_pkg::KIND_RECT;
					emit_rect = rd_data_q;
					emit_last = rd_q == count_q;
					if (rd_q == count_q) begin
						count_d = '0;
						cmd_pop = 1'b1;
						state_d = drt_pkg::B_IDLE;
					end
				end else if (out_free && rd_q != count_q) begin
					mem_re = 1'b1;
					rd_d   = rd_q + 1'b1;
					pend_d = 1'b1;
				end
			end
			default: begin
				state_d = drt_pkg::B_IDLE;
			end
		endcase

		if (finish) begin
			if (second_q) begin
				work_d   = cmd.rect;
				second_d = 1'b0;
				state_d  = drt_pkg::B_ADD;
			end else begin
				if (cmd.op == drt_pkg::OP_CURSOR) begin
					cur_x_d = cmd.pos_x;
					cur_y_d = cmd.pos_y;
				end
				cmd_pop = 1'b1;
				state_d = drt_pkg::B_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= drt_pkg::B_IDLE;
			count_q   <= '0;
			rd_q      <= '0;
			pend_q    <= 1'b0;
			full_q    <= 1'b1;
			known_q   <= 1'b0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			second_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_q      <= rd_d;
			pend_q    <= pend_d;
			full_q    <= full_d;
			known_q   <= known_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			second_q  <= second_d;
			out_vld_q <= emit || (out_vld_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		work_q <= work_d;
		if (emit) begin
			out_kind_q <= emit_kind;
			out_rect_q <= emit_rect;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[drt_pkg::IDX_W-1:0]] <= work_q.r;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_q[drt_pkg::IDX_W-1:0]];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= drt_pkg::CNT_W'(drt_pkg::MAX_RECTS))
		else $error("rect count above capacity");

	a_flush_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drt_pkg::B_FLUSH && pend_q) |-> !out_vld_q)
		else $error("render read returned while output register busy");

	a_flush_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drt_pkg::B_FLUSH || state_q == drt_pkg::B_SEARCH) |-> !full_q)
		else $error("list walk while full redraw set");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_vld)
		else $error("pop from empty queue");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrites pending transaction");
`endif

endmodule

/* hw/rtl/damage_rect_tracker_top.sv */
// -----------------------------------------------------------------------------
// damage_rect_tracker_top: screen damage rectangle list
// Operations on channel ops (damage, mark full, cursor move, render) are
// decoded and clipped by the front, queued, and applied to the list by the
// back. A render returns one or more transactions on rsp; the others none.
// Channel cfg writes screen_width (index 0) and screen_height (index 1); it
// is always ready and must only be used while the block is idle.
// An operation is registered in the front and held in the queue before
// the back starts it. In the back mark full is done in the idle state; a
// damage is appended at once to an empty list, otherwise after a search
// that compares it with each stored rectangle; a cursor move adds the old
// and then the new cursor box that way. A render returns a full-frame or
// no-op result at once, else reads the store through its single read port.
// After reset the list is empty, full redraw is set, the cursor is unknown
// and the screen is 1024 x 768. A stalled rsp holds the result in the
// output register; the back stops only when it needs that register, and
// the queue keeps taking operations until it fills.
// -----------------------------------------------------------------------------
module damage_rect_tracker_top (
	input  logic       clk,
	input  logic       arst_n,
	drt_cfg_if.sink    cfg,
	drt_in_if.sink     ops,
	drt_out_if.source  rsp
);

	logic [drt_pkg::DIM_W-1:0]  sw_q;
	logic [drt_pkg::DIM_W-1:0]  sh_q;
	logic [drt_pkg::DIM_W-1:0]  sw;
	logic [drt_pkg::DIM_W-1:0]  sh;
	logic                       push;
	drt_pkg::cmd_t              push_cmd;
	logic                       q_rdy;
	logic                       head_vld;
	drt_pkg::cmd_t              head;
	logic                       pop;

	assign cfg.ready = 1'b1;
	assign sw = (sw_q > drt_pkg::DIM_W'(drt_pkg::SCREEN_LIMIT))
		? drt_pkg::DIM_W'(drt_pkg::SCREEN_LIMIT) : sw_q;
	assign sh = (sh_q > drt_pkg::DIM_W'(drt_pkg::SCREEN_LIMIT))
		? drt_pkg::DIM_W'(drt_pkg::SCREEN_LIMIT) : sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= drt_pkg::DIM_W'(1024);
			sh_q <= drt_pkg::DIM_W'(768);
		end else if (cfg.valid) begin
			case (cfg.index)
				drt_pkg::REG_SCREEN_WIDTH:  sw_q <= cfg.data;
				drt_pkg::REG_SCREEN_HEIGHT: sh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	drt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ops      (ops),
		.sw       (sw),
		.sh       (sh),
		.push     (push),
		.push_cmd (push_cmd),
		.q_rdy    (q_rdy)
	);

	drt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_rdy    (q_rdy),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop)
	);

	drt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.sw      (sw),
		.sh      (sh),
		.cmd_vld (head_vld),
		.cmd     (head),
		.cmd_pop (pop),
		.rsp     (rsp)
	);

endmodule

/* tb/sv/tb_damage_rect_tracker_top.sv */
// -----------------------------------------------------------------------------
// tb_damage_rect_tracker_top: damage rectangle tracker testbench
// Drives operations with random gaps and stalls the result channel at random.
// A predictor keeps its own dirty list, redraw flag and cursor position,
// queues the transactions each render should return, and every result is
// checked field by field. Covers the state after reset, clipping, padding,
// duplicates, cursor boxes, overflow and several screen sizes.
// -----------------------------------------------------------------------------
module tb_damage_rect_tracker_top;
	import drt_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 300;
	localparam int MAX_WAIT      = 18;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] rw;
		logic signed [POS_W-1:0] rh;
		logic [PAD_W-1:0]        pad;
	} op_item_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		rect_t             r;
		logic              last;
	} render_rec_t;

	logic clk;
	logic arst_n;

	drt_cfg_if cfg_if ();
	drt_in_if  ops_if ();
	drt_out_if rsp_if ();

	damage_rect_tracker_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.ops    (ops_if),
		.rsp    (rsp_if)
	);

	logic [DIM_W-1:0] scr_w;
	logic [DIM_W-1:0] scr_h;
	rect_t            dirty_list [MAX_RECTS];
	int               dirty_cnt;
	bit               redraw_all;
	bit               ptr_known;
	int               ptr_x;
	int               ptr_y;
	render_rec_t      render_due [$];
	int               mismatch_count = 0;
	bit               ops_calm = 1'b0;
	bit               rsp_calm = 1'b0;
	op_item_t         last_damage;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int clip_dim(input logic [DIM_W-1:0] v);
		return (v > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(v);
	endfunction

	function automatic void reset_tracker();
		scr_w      = 13'd1024;
		scr_h      = 13'd768;
		dirty_cnt  = 0;
		redraw_all = 1'b1;
		ptr_known  = 1'b0;
		ptr_x      = 0;
		ptr_y      = 0;
	endfunction

	function automatic void push_result(input logic [KIND_W-1:0] kind, input rect_t r,
		input logic last);
		render_rec_t rec;
		rec.kind = kind;
		rec.r    = r;
		rec.last = last;
		render_due.push_back(rec);
	endfunction

	function automatic void add_dirty(input int x, input int y, input int w, input int h);
		int sw;
		int sh;
		int i;
		sw = clip_dim(scr_w);
		sh = clip_dim(scr_h);
		if (redraw_all || w <= 0 || h <= 0)
			return;
		if (x < 0) begin
			w += x;
			x = 0;
		end
		if (y < 0) begin
			h += y;
			y = 0;
		end
		if (x + w > sw)
			w = sw - x;
		if (y + h > sh)
			h = sh - y;
		if (w <= 0 || h <= 0)
			return;
		if (dirty_cnt >= MAX_RECTS) begin
			redraw_all = 1'b1;
			dirty_cnt  = 0;
			return;
		end
		for (i = 0; i < dirty_cnt; i++) begin
			if (dirty_list[i].x == x[XY_W-1:0] && dirty_list[i].y == y[XY_W-1:0] &&
				dirty_list[i].w == w[DIM_W-1:0] && dirty_list[i].h == h[DIM_W-1:0])
				return;
		end
		dirty_list[dirty_cnt].x = x[XY_W-1:0];
		dirty_list[dirty_cnt].y = y[XY_W-1:0];
		dirty_list[dirty_cnt].w = w[DIM_W-1:0];
		dirty_list[dirty_cnt].h = h[DIM_W-1:0];
		dirty_cnt++;
	endfunction

	function automatic void track_op(input op_item_t it);
		int    pad_i;
		int    i;
		rect_t none_r;
		pad_i  = int'(it.pad);
		none_r = '0;
		case (it.op)
			OP_DAMAGE: begin
				add_dirty(int'(it.px) - pad_i, int'(it.py) - pad_i,
					int'(it.rw) + 2 * pad_i, int'(it.rh) + 2 * pad_i);
			end
			OP_FULL: begin
				redraw_all = 1'b1;
				dirty_cnt  = 0;
			end
			OP_CURSOR: begin
				if (!ptr_known) begin
					ptr_x     = int'(it.px);
					ptr_y     = int'(it.py);
					ptr_known = 1'b1;
				end else if (!redraw_all) begin
					add_dirty(ptr_x - CURSOR_OFS, ptr_y - CURSOR_OFS, CURSOR_BOX_W, CURSOR_BOX_H);
					add_dirty(int'(it.px) - CURSOR_OFS, int'(it.py) - CURSOR_OFS,
						CURSOR_BOX_W, CURSOR_BOX_H);
					ptr_x = int'(it.px);
					ptr_y = int'(it.py);
				end
			end
			OP_FLUSH: begin
				if (redraw_all) begin
					push_result(KIND_FULL, none_r, 1'b1);
					redraw_all = 1'b0;
				end else if (dirty_cnt == 0) begin
					push_result(KIND_NONE, none_r, 1'b1);
				end else begin
					for (i = 0; i < dirty_cnt; i++)
						push_result(KIND_RECT, dirty_list[i], i == dirty_cnt - 1);
				end
				dirty_cnt = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic op_item_t mk_op(input logic [OP_W-1:0] op, input int x, input int y,
		input int w, input int h, input int p);
		op_item_t it;
		it.op  = op;
		it.px  = x[POS_W-1:0];
		it.py  = y[POS_W-1:0];
		it.rw  = w[POS_W-1:0];
		it.rh  = h[POS_W-1:0];
		it.pad = p[PAD_W-1:0];
		return it;
	endfunction

	function automatic op_item_t draw_damage();
		int       sw;
		int       sh;
		int       w;
		int       h;
		int       p;
		int       sel;
		op_item_t it;
		sw = clip_dim(scr_w);
		sh = clip_dim(scr_h);
		if ($urandom_range(0, 7) == 0)
			return last_damage;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			it = mk_op(OP_DAMAGE, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255));
		end else begin
			w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 5000))
				: int'($urandom_range(0, 130)) - 10;
			h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 5000))
				: int'($urandom_range(0, 130)) - 10;
			if (sel < 6)
				p = 0;
			else if (sel < 9)
				p = $urandom_range(1, 8);
			else
				p = $urandom_range(0, 255);
			it = mk_op(OP_DAMAGE, int'($urandom_range(0, sw + 80)) - 40,
				int'($urandom_range(0, sh + 80)) - 40, w, h, p);
		end
		last_damage = it;
		return it;
	endfunction

	function automatic op_item_t draw_cursor();
		int sw;
		int sh;
		sw = clip_dim(scr_w);
		sh = clip_dim(scr_h);
		if ($urandom_range(0, 9) == 0)
			return mk_op(OP_CURSOR, $urandom, $urandom, $urandom, $urandom, $urandom);
		return mk_op(OP_CURSOR, int'($urandom_range(0, sw + 60)) - 30,
			int'($urandom_range(0, sh + 60)) - 30, $urandom, $urandom, $urandom);
	endfunction

	task automatic issue_op(input op_item_t it);
		int gap;
		gap = ops_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			ops_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ops_if.valid     <= 1'b1;
		ops_if.operation <= it.op;
		ops_if.pos_x     <= it.px;
		ops_if.pos_y     <= it.py;
		ops_if.rect_w    <= it.rw;
		ops_if.rect_h    <= it.rh;
		ops_if.pad       <= it.pad;
		do @(posedge clk); while (ops_if.ready !== 1'b1);
		track_op(it);
	endtask

	task automatic wait_results_done();
		ops_if.valid <= 1'b0;
		@(posedge clk);
		while (render_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_SCREEN_WIDTH;
		cfg_if.data  <= w;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		scr_w = w;
		cfg_if.index <= REG_SCREEN_HEIGHT;
		cfg_if.data  <= h;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		scr_h = h;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic reconfigure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_screen(w, h);
	endtask

	// bursts of mostly damage and cursor moves, closed by a render; some bursts
	// are long enough to overflow the list
	task automatic run_traffic(input int n_items);
		int       sent;
		int       seq_len;
		int       seq_no;
		int       k;
		int       r;
		op_item_t it;
		sent   = 0;
		seq_no = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0)
				ops_calm = !ops_calm;
			seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(34, 46) : $urandom_range(0, 10);
			if (seq_len > n_items - sent - 1)
				seq_len = n_items - sent - 1;
			for (k = 0; k < seq_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 68)
					it = draw_damage();
				else if (r < 86)
					it = draw_cursor();
				else if (r < 89)
					it = mk_op(OP_FULL, $urandom, $urandom, $urandom, $urandom, $urandom);
				else if (r < 92)
					it = mk_op(OP_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
				else
					it = mk_op(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						$urandom, $urandom);
				issue_op(it);
			end
			issue_op(mk_op(OP_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom));
			sent += seq_len + 1;
			seq_no++;
			if (seq_no == 2 || $urandom_range(0, 9) == 0)
				wait_results_done();
		end
	endtask

	task automatic test_reset_flush();
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
		issue_op(mk_op(OP_FLUSH, -1, -1, -1, -1, 255));
		issue_op(mk_op(OP_CURSOR, 100, 100, 0, 0, 0));
	endtask

	task automatic test_damage_clipping();
		issue_op(mk_op(OP_DAMAGE, 10, 20, 30, 40, 0));
		issue_op(mk_op(OP_DAMAGE, 10, 20, 30, 40, 0));
		issue_op(mk_op(OP_DAMAGE, 5, 5, 0, 10, 0));
		issue_op(mk_op(OP_DAMAGE, 5, 5, -1, -1, 1));
		issue_op(mk_op(OP_DAMAGE, -32768, -32768, 32767, 32767, 255));
		issue_op(mk_op(OP_DAMAGE, 32767, 32767, 32767, 32767, 0));
		issue_op(mk_op(OP_DAMAGE, 1000, 700, 100, 100, 255));
		issue_op(mk_op(OP_DAMAGE, 100, 100, -32768, 5, 255));
		// padded copy of the first rectangle
		issue_op(mk_op(OP_DAMAGE, 11, 21, 28, 38, 1));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
	endtask

	task automatic test_cursor_moves();
		issue_op(mk_op(OP_CURSOR, 200, 300, 0, 0, 0));
		issue_op(mk_op(OP_CURSOR, 0, 0, 0, 0, 0));
		issue_op(mk_op(OP_CURSOR, 1020, 760, 0, 0, 0));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
		issue_op(mk_op(OP_FULL, 0, 0, 0, 0, 0));
		issue_op(mk_op(OP_DAMAGE, 10, 10, 5, 5, 0));
		issue_op(mk_op(OP_CURSOR, 500, 500, 0, 0, 0));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
		issue_op(mk_op(OP_CURSOR, -32768, 32767, 0, 0, 0));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
	endtask

	// a full list rendered, then one rectangle past capacity
	task automatic test_overflow();
		int k;
		for (k = 0; k < MAX_RECTS; k++)
			issue_op(mk_op(OP_DAMAGE, 4 * k, 8, 3, 3, 0));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
		for (k = 0; k < MAX_RECTS + 1; k++)
			issue_op(mk_op(OP_DAMAGE, 4 * k, 16, 3, 3, 0));
		issue_op(mk_op(OP_FLUSH, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic();
		run_traffic(120);
	endtask

	task automatic test_screen_extremes();
		reconfigure(13'd1, 13'd1);
		run_traffic(15);
		reconfigure(13'd4096, 13'd4096);
		run_traffic(50);
		reconfigure(13'd0, 13'd0);
		run_traffic(15);
		reconfigure(13'd8191, 13'd8191);
		run_traffic(25);
		reconfigure(13'd0, 13'd4096);
		run_traffic(10);
		reconfigure(DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)));
		run_traffic(40);
	endtask

	initial begin : result_check
		render_rec_t exp_rec;
		int          stall;
		rsp_if.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				rsp_calm = !rsp_calm;
			stall = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			if (render_due.size() == 0) begin
				report_mismatch($sformatf("transaction kind %0d with nothing pending",
					rsp_if.kind));
			end else begin
				exp_rec = render_due.pop_front();
				if (rsp_if.kind !== exp_rec.kind || rsp_if.out_x !== exp_rec.r.x ||
					rsp_if.out_y !== exp_rec.r.y || rsp_if.out_w !== exp_rec.r.w ||
					rsp_if.out_h !== exp_rec.r.h || rsp_if.last !== exp_rec.last)
					report_mismatch($sformatf(
						"got kind %0d x %0d y %0d w %0d h %0d last %0b, want %0d %0d %0d %0d %0d %0b",
						rsp_if.kind, rsp_if.out_x, rsp_if.out_y, rsp_if.out_w, rsp_if.out_h,
						rsp_if.last, exp_rec.kind, exp_rec.r.x, exp_rec.r.y, exp_rec.r.w,
						exp_rec.r.h, exp_rec.last));
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((ops_if.valid && ops_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		ops_if.valid     <= 1'b0;
		ops_if.operation <= OP_DAMAGE;
		ops_if.pos_x     <= '0;
		ops_if.pos_y     <= '0;
		ops_if.rect_w    <= '0;
		ops_if.rect_h    <= '0;
		ops_if.pad       <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= REG_SCREEN_WIDTH;
		cfg_if.data      <= '0;
		reset_tracker();
		last_damage = mk_op(OP_DAMAGE, 16, 16, 8, 8, 0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_flush();
		test_damage_clipping();
		test_cursor_moves();
		test_overflow();
		test_random_traffic();
		test_screen_extremes();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (render_due.size() != 0)
			report_mismatch($sformatf("%0d transactions never arrived", render_due.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
